@@ rtl/core/mch_pkg.sv @@
package mch_pkg;

    // Field widths of one item.
    localparam int W_SLOPE = 32;
    localparam int W_ICPT  = 48;
    localparam int W_X     = 24;
    localparam int W_VALUE = 64;

    // Datapath widths: intercept and slope differences, products, sums.
    localparam int W_PDIFF = W_ICPT + 1;
    localparam int W_QDIFF = W_SLOPE + 1;
    localparam int W_MOP   = 33;
    localparam int W_PROD  = 2 * W_MOP;
    localparam int W_ACC   = W_PDIFF + W_QDIFF;

    // Item kinds.
    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Operand pairs of the shared multiplier.
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_NONE     = 3'd0;
    localparam t_mul_sel MUL_LO_P1_Q2 = 3'd1;
    localparam t_mul_sel MUL_HI_P1_Q2 = 3'd2;
    localparam t_mul_sel MUL_LO_P2_Q1 = 3'd3;
    localparam t_mul_sel MUL_HI_P2_Q1 = 3'd4;
    localparam t_mul_sel MUL_X_Q      = 3'd5;
    localparam t_mul_sel MUL_M_X      = 3'd6;

    // Accumulator operations.
    typedef logic [2:0] t_acc_op;
    localparam t_acc_op ACC_NONE   = 3'd0;
    localparam t_acc_op ACC_LOAD_A = 3'd1;
    localparam t_acc_op ACC_ADD_A  = 3'd2;
    localparam t_acc_op ACC_LOAD_B = 3'd3;
    localparam t_acc_op ACC_ADD_B  = 3'd4;
    localparam t_acc_op ACC_QUERY  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     load_diff;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     pop;
        logic     advance;
        logic     push_write;
        logic     out_en;
        t_status  out_status;
        logic     out_value;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic count_lt2;
        logic fp_last;
        logic slope_gt;
        logic slope_eq;
        logic icpt_ge;
        logic cmp_gt;
    } t_dp_stat;

endpackage

@@ rtl/core/mch_ctrl.sv @@
module mch_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_kind,
    input  mch_pkg::t_dp_stat i_stat,
    output mch_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import mch_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PCHK  = 5'd1;
    localparam logic [4:0] S_PTOP  = 5'd2;
    localparam logic [4:0] S_PWAIT = 5'd3;
    localparam logic [4:0] S_PHEAD = 5'd4;
    localparam logic [4:0] S_PM0   = 5'd5;
    localparam logic [4:0] S_PM1   = 5'd6;
    localparam logic [4:0] S_PM2   = 5'd7;
    localparam logic [4:0] S_PM3   = 5'd8;
    localparam logic [4:0] S_PM4   = 5'd9;
    localparam logic [4:0] S_PCMP  = 5'd10;
    localparam logic [4:0] S_PWR   = 5'd11;
    localparam logic [4:0] S_QCHK  = 5'd12;
    localparam logic [4:0] S_QLOOP = 5'd13;
    localparam logic [4:0] S_QM    = 5'd14;
    localparam logic [4:0] S_QACC  = 5'd15;
    localparam logic [4:0] S_QCMP  = 5'd16;
    localparam logic [4:0] S_QVAL  = 5'd17;
    localparam logic [4:0] S_QOUT  = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;
    t_dp_cmd    cmd;

    // Next state and command decode.
    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.mul_sel    = MUL_NONE;
        cmd.acc_op     = ACC_NONE;
        cmd.out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.capture = 1'b1;
                    n_state     = (i_kind == KIND_PUSH) ? S_PCHK : S_QCHK;
                end
            end
            // The read of the top two lines is in flight here.
            S_PCHK: begin
                if (i_stat.count_full) begin
                    cmd.out_en     = 1'b1;
                    cmd.out_status = ST_FULL;
                    n_state        = S_IDLE;
                end else if (i_stat.count_zero) begin
                    n_state = S_PWR;
                end else begin
                    n_state = S_PTOP;
                end
            end
            // Rising slope, or equal slope without a lower intercept, is ignored.
            S_PTOP: begin
                if (i_stat.slope_gt || (i_stat.slope_eq && i_stat.icpt_ge)) begin
                    cmd.out_en = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_stat.slope_eq) begin
                    cmd.pop = 1'b1;
                    n_state = S_PWAIT;
                end else begin
                    n_state = S_PHEAD;
                end
            end
            S_PWAIT: n_state = S_PHEAD;
            S_PHEAD: begin
                if (i_stat.count_lt2) begin
                    n_state = S_PWR;
                end else begin
                    cmd.load_diff = 1'b1;
                    n_state       = S_PM0;
                end
            end
            // Both cross products, two partial products each.
            S_PM0: begin
                cmd.mul_sel = MUL_LO_P1_Q2;
                n_state     = S_PM1;
            end
            S_PM1: begin
                cmd.mul_sel = MUL_HI_P1_Q2;
                cmd.acc_op  = ACC_LOAD_A;
                n_state     = S_PM2;
            end
            S_PM2: begin
                cmd.mul_sel = MUL_LO_P2_Q1;
                cmd.acc_op  = ACC_ADD_A;
                n_state     = S_PM3;
            end
            S_PM3: begin
                cmd.mul_sel = MUL_HI_P2_Q1;
                cmd.acc_op  = ACC_LOAD_B;
                n_state     = S_PM4;
            end
            S_PM4: begin
                cmd.acc_op = ACC_ADD_B;
                n_state    = S_PCMP;
            end
            S_PCMP: begin
                if (i_stat.cmp_gt) begin
                    cmd.pop = 1'b1;
                    n_state = S_PWAIT;
                end else begin
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                cmd.push_write = 1'b1;
                cmd.out_en     = 1'b1;
                n_state        = S_IDLE;
            end
            // The read of the front line and its successor is in flight here.
            S_QCHK: begin
                if (i_stat.count_zero) begin
                    cmd.out_en     = 1'b1;
                    cmd.out_status = ST_EMPTY;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_QLOOP;
                end
            end
            S_QLOOP: begin
                if (i_stat.fp_last) begin
                    n_state = S_QVAL;
                end else begin
                    cmd.load_diff = 1'b1;
                    n_state       = S_QM;
                end
            end
            S_QM: begin
                cmd.mul_sel = MUL_X_Q;
                n_state     = S_QACC;
            end
            S_QACC: begin
                cmd.acc_op = ACC_QUERY;
                n_state    = S_QCMP;
            end
            // Advance while the next intersection is at or left of x.
            S_QCMP: begin
                if (i_stat.cmp_gt) begin
                    n_state = S_QVAL;
                end else begin
                    cmd.advance = 1'b1;
                    n_state     = S_QCHK;
                end
            end
            S_QVAL: begin
                cmd.mul_sel = MUL_M_X;
                n_state     = S_QOUT;
            end
            S_QOUT: begin
                cmd.out_en    = 1'b1;
                cmd.out_value = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/mch_datapath.sv @@
module mch_datapath #(
    parameter int MAX_LINES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mch_pkg::t_dp_cmd                    i_cmd,
    output mch_pkg::t_dp_stat                   o_stat,
    input  logic                                i_kind,
    input  logic signed [mch_pkg::W_SLOPE-1:0]  i_slope,
    input  logic signed [mch_pkg::W_ICPT-1:0]   i_intercept,
    input  logic        [mch_pkg::W_X-1:0]      i_query_x,
    output logic                                o_valid,
    output logic signed [mch_pkg::W_VALUE-1:0]  o_value,
    output mch_pkg::t_status                    o_status
);
    import mch_pkg::*;

    localparam int IW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    // Captured item.
    logic                      r_kind;
    logic signed [W_SLOPE-1:0] r_m;
    logic signed [W_ICPT-1:0]  r_b;
    logic        [W_X-1:0]     r_x;

    // Stack depth and front pointer.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [IW-1:0] r_fp;
    logic [IW-1:0] n_fp;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [CW-1:0] fp_inc;

    // Line store and its registered read ports.
    logic signed [W_SLOPE-1:0] mem_slope [MAX_LINES];
    logic signed [W_ICPT-1:0]  mem_icpt  [MAX_LINES];
    logic        [IW-1:0]      addr_a;
    logic        [IW-1:0]      addr_b;
    logic signed [W_SLOPE-1:0] rd_a_s;
    logic signed [W_SLOPE-1:0] rd_b_s;
    logic signed [W_ICPT-1:0]  rd_a_b;
    logic signed [W_ICPT-1:0]  rd_b_b;

    // Differences, multiplier and accumulators.
    logic signed [W_PDIFF-1:0] r_p1;
    logic signed [W_QDIFF-1:0] r_q1;
    logic signed [W_PDIFF-1:0] r_p2;
    logic signed [W_QDIFF-1:0] r_q2;
    logic signed [W_MOP-1:0]   mul_a;
    logic signed [W_MOP-1:0]   mul_b;
    logic signed [W_PROD-1:0]  r_prod;
    logic signed [W_ACC-1:0]   prod_ext;
    logic signed [W_ACC-1:0]   prod_hi;
    logic signed [W_ACC-1:0]   r_acc_a;
    logic signed [W_ACC-1:0]   r_acc_b;

    logic                      r_valid;
    logic signed [W_VALUE-1:0] r_value;
    t_status                   r_status;

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_m    <= i_slope;
            r_b    <= i_intercept;
            r_x    <= i_query_x;
        end
    end

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);
    assign fp_inc = CW'(r_fp) + CW'(1);

    // A push reads the top two lines, a query the front line and the next.
    assign addr_a = (r_kind == KIND_PUSH) ? cnt_m1[IW-1:0] : r_fp;
    assign addr_b = (r_kind == KIND_PUSH) ? cnt_m2[IW-1:0] : r_fp + IW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_write) begin
            mem_slope[r_count[IW-1:0]] <= r_m;
        end
        rd_a_s <= mem_slope[addr_a];
        rd_b_s <= mem_slope[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_write) begin
            mem_icpt[r_count[IW-1:0]] <= r_b;
        end
        rd_a_b <= mem_icpt[addr_a];
        rd_b_b <= mem_icpt[addr_b];
    end

    // Pops, pointer advance, and the store of a new line with pointer clamp.
    always_comb begin
        n_count = r_count;
        n_fp    = r_fp;
        if (i_cmd.pop) begin
            n_count = cnt_m1;
        end
        if (i_cmd.advance) begin
            n_fp = r_fp + IW'(1);
        end
        if (i_cmd.push_write) begin
            n_count = r_count + CW'(1);
            if (r_count == '0) begin
                n_fp = '0;
            end else if (CW'(r_fp) > cnt_m1) begin
                n_fp = cnt_m1[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fp    <= '0;
        end else begin
            r_count <= n_count;
            r_fp    <= n_fp;
        end
    end

    // Intersection numerators and denominators; denominators are positive.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_diff) begin
            if (r_kind == KIND_PUSH) begin
                r_p1 <= {rd_a_b[W_ICPT-1], rd_a_b} - {rd_b_b[W_ICPT-1], rd_b_b};
                r_q1 <= {rd_b_s[W_SLOPE-1], rd_b_s} - {rd_a_s[W_SLOPE-1], rd_a_s};
                r_p2 <= {r_b[W_ICPT-1], r_b} - {rd_a_b[W_ICPT-1], rd_a_b};
                r_q2 <= {rd_a_s[W_SLOPE-1], rd_a_s} - {r_m[W_SLOPE-1], r_m};
            end else begin
                r_p1 <= {rd_b_b[W_ICPT-1], rd_b_b} - {rd_a_b[W_ICPT-1], rd_a_b};
                r_q1 <= {rd_a_s[W_SLOPE-1], rd_a_s} - {rd_b_s[W_SLOPE-1], rd_b_s};
            end
        end
    end

    // Operand select for the shared 33x33 signed multiplier. A numerator is
    // split into an unsigned low word and a signed high part.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_LO_P1_Q2: begin
                mul_a = {1'b0, r_p1[31:0]};
                mul_b = r_q2;
            end
            MUL_HI_P1_Q2: begin
                mul_a = {{16{r_p1[W_PDIFF-1]}}, r_p1[W_PDIFF-1:32]};
                mul_b = r_q2;
            end
            MUL_LO_P2_Q1: begin
                mul_a = {1'b0, r_p2[31:0]};
                mul_b = r_q1;
            end
            MUL_HI_P2_Q1: begin
                mul_a = {{16{r_p2[W_PDIFF-1]}}, r_p2[W_PDIFF-1:32]};
                mul_b = r_q1;
            end
            MUL_X_Q: begin
                mul_a = {{(W_MOP - W_X){1'b0}}, r_x};
                mul_b = r_q1;
            end
            MUL_M_X: begin
                mul_a = {rd_a_s[W_SLOPE-1], rd_a_s};
                mul_b = {{(W_MOP - W_X){1'b0}}, r_x};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // A high partial product fits 50 signed bits and lands 32 bits up.
    assign prod_ext = {{(W_ACC - W_PROD){r_prod[W_PROD-1]}}, r_prod};
    assign prod_hi  = {r_prod[49:0], 32'b0};

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD_A: r_acc_a <= prod_ext;
            ACC_ADD_A:  r_acc_a <= r_acc_a + prod_hi;
            ACC_LOAD_B: r_acc_b <= prod_ext;
            ACC_ADD_B:  r_acc_b <= r_acc_b + prod_hi;
            ACC_QUERY: begin
                r_acc_a <= {{(W_ACC - W_PDIFF){r_p1[W_PDIFF-1]}}, r_p1};
                r_acc_b <= prod_ext;
            end
            default: begin
                r_acc_a <= r_acc_a;
                r_acc_b <= r_acc_b;
            end
        endcase
    end

    // Status toward the controller.
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == CW'(MAX_LINES));
    assign o_stat.count_lt2  = (r_count < CW'(2));
    assign o_stat.fp_last    = (fp_inc >= r_count);
    assign o_stat.slope_gt   = (r_m > rd_a_s);
    assign o_stat.slope_eq   = (r_m == rd_a_s);
    assign o_stat.icpt_ge    = (r_b >= rd_a_b);
    assign o_stat.cmp_gt     = (r_acc_a > r_acc_b);

    // Result register; the strobe lasts one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_status <= i_cmd.out_status;
            if (i_cmd.out_value) begin
                r_value <= r_prod[W_VALUE-1:0]
                         + {{(W_VALUE - W_ICPT){rd_a_b[W_ICPT-1]}}, rd_a_b};
            end else begin
                r_value <= '0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LINES))
        else $error("line count beyond store depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from an empty stack");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_write |-> (r_count != CW'(MAX_LINES)))
        else $error("line stored into a full store");

    a_advance_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |=> (CW'(r_fp) < r_count))
        else $error("front pointer advanced past the top line");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

endmodule

@@ rtl/core/monotone_convex_hull_trick.sv @@
// Push: a full store is refused, the first line is stored, an ignored line is only
// reported. Else an equal-slope top line is popped, top lines are popped while a compare
// shows them redundant, and the new line is stored. Query: an empty hull is reported;
// else the front pointer advances while the next intersection is at or left of x, and
// the front line's m*x+b is returned. The result strobe falls in the first cycle with
// busy low. Synchronous active-low reset empties the hull; the receiver cannot stall.
module monotone_convex_hull_trick #(
    parameter int MAX_LINES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_kind,
    input  logic signed [mch_pkg::W_SLOPE-1:0]  i_slope,
    input  logic signed [mch_pkg::W_ICPT-1:0]   i_intercept,
    input  logic        [mch_pkg::W_X-1:0]      i_query_x,
    output logic                                o_valid,
    output logic signed [mch_pkg::W_VALUE-1:0]  o_value,
    output mch_pkg::t_status                    o_status
);
    import mch_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer for pops, pointer advances and result transfers.
    mch_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Line store, multiplier and result register.
    mch_datapath #(
        .MAX_LINES (MAX_LINES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (i_kind),
        .i_slope     (i_slope),
        .i_intercept (i_intercept),
        .i_query_x   (i_query_x),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
